@@ hdl/cdc_pkg.sv @@
package cdc_pkg;

    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned WD_W   = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned MODE_W = 2;

    // command codes
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    // date after reset: thursday 1 january 1970
    localparam logic [DAY_W-1:0]  RST_DAY   = 5'd1;
    localparam logic [MON_W-1:0]  RST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0] RST_YEAR  = 14'd1970;
    localparam logic [WD_W-1:0]   RST_WDAY  = 3'd4;

    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;
    localparam logic [DAY_W-1:0] DAY_LAST_DEC = 5'd31;
    localparam logic [WD_W-1:0]  WD_SUN = 3'd0;
    localparam logic [WD_W-1:0]  WD_SAT = 3'd6;

    // floor(2^20 / 25), quotient off by at most one below
    localparam logic [15:0] RECIP25    = 16'd41943;
    localparam int unsigned PROD_W     = YEAR_W + 16;
    localparam int unsigned RECIP_SH   = 20;
    localparam int unsigned QUOT_W     = PROD_W - RECIP_SH;
    localparam int unsigned SUM_W      = 15;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DAY_W-1:0]  new_day;
        logic [MON_W-1:0]  new_month;
        logic [YEAR_W-1:0] new_year;
        logic [CNT_W-1:0]  day_count;
    } t_in;

    typedef struct packed {
        logic [DAY_W-1:0]  cur_day;
        logic [MON_W-1:0]  cur_month;
        logic [YEAR_W-1:0] cur_year;
        logic [WD_W-1:0]   weekday;
        logic              is_leap;
        logic [ST_W-1:0]   status;
    } t_out;

    // operand select for the divide-by-25 unit
    typedef enum logic [1:0] {
        SRC_NEWY = 2'd0,
        SRC_YEAR = 2'd1,
        SRC_YYQ4 = 2'd2
    } t_src;

    typedef struct packed {
        logic capture;
        logic mul;
        t_src src;
        logic set_chk;
        logic leap_upd;
        logic q_load;
        logic sum_load;
        logic wday_load;
        logic adv_step;
        logic next_day;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              set_ok;
        logic              cnt_zero;
        logic              weekend;
        logic              ovf_hit;
        logic              year_wrap;
        logic              out_free;
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // month term of the sakamoto weekday formula
    function automatic logic [WD_W-1:0] wk_offset(input logic [MON_W-1:0] m);
        logic [WD_W-1:0] off;
        case (m)
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // mod 7 by summing octal digits, since 8 is 1 mod 7
    function automatic logic [WD_W-1:0] mod7_6(input logic [5:0] v);
        logic [3:0] s;
        logic [3:0] t;
        s = {1'b0, v[5:3]} + {1'b0, v[2:0]};
        t = {3'b000, s[3]} + {1'b0, s[2:0]};
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    function automatic logic [WD_W-1:0] mod7_15(input logic [SUM_W-1:0] v);
        logic [5:0] s;
        s = {3'b000, v[14:12]} + {3'b000, v[11:9]} + {3'b000, v[8:6]}
          + {3'b000, v[5:3]} + {3'b000, v[2:0]};
        return mod7_6(s);
    endfunction

endpackage

@@ hdl/cdc_dp.sv @@
module cdc_dp import cdc_pkg::*; #(
    parameter int MAX_YEAR = 9999,
    parameter int MIN_YEAR = 1970
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    localparam logic [YEAR_W-1:0] YEAR_HI = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] YEAR_LO = YEAR_W'(MIN_YEAR);

    // held item
    logic [MODE_W-1:0] r_mode;
    logic [DAY_W-1:0]  r_nd;
    logic [MON_W-1:0]  r_nm;
    logic [YEAR_W-1:0] r_ny;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // calendar state
    logic [DAY_W-1:0]  r_day, n_day;
    logic [MON_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [WD_W-1:0]   r_wday, n_wday;
    logic              r_leap, n_leap;
    logic [ST_W-1:0]   r_status, n_status;

    // divide-by-25 unit and weekday sum
    logic [YEAR_W-1:0] r_op;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_q100;
    logic [SUM_W-1:0]  r_sum;

    t_out r_out;
    logic r_out_valid;

    logic [YEAR_W-1:0] yy;
    logic [YEAR_W-1:0] src_val;
    logic [QUOT_W-1:0] q0;
    logic [QUOT_W-1:0] quot;
    logic [YEAR_W-1:0] q25;
    logic [YEAR_W-1:0] rem_raw;
    logic [YEAR_W-1:0] rem25;
    logic              rem_hi;
    logic              op_leap;
    logic              set_ok;
    logic [DAY_W-1:0]  len_cur;
    logic [DAY_W-1:0]  left;
    logic              fits;
    logic              cnt_zero;
    logic              ovf_hit;
    logic              year_wrap;
    logic [DAY_W-1:0]  add5;
    logic [SUM_W-1:0]  wd_sum;

    // year term of the weekday formula, january and february count to the year before
    assign yy = r_year - ((r_month < MON_MAR) ? YEAR_W'(1) : YEAR_W'(0));

    always_comb begin
        case (i_cmd.src)
            SRC_NEWY: src_val = r_ny;
            SRC_YEAR: src_val = r_year;
            default:  src_val = {2'b00, yy[YEAR_W-1:2]};
        endcase
    end

    assign q0      = r_prod[PROD_W-1:RECIP_SH];
    assign q25     = YEAR_W'(q0) * YEAR_W'(25);
    assign rem_raw = r_op - q25;
    assign rem_hi  = rem_raw >= YEAR_W'(25);
    assign rem25   = rem_hi ? (rem_raw - YEAR_W'(25)) : rem_raw;
    assign quot    = rem_hi ? (q0 + QUOT_W'(1)) : q0;

    assign op_leap = (r_op[1:0] == 2'b00) && ((rem25 != '0) || (r_op[3:0] == 4'h0));

    assign set_ok = (r_nd != '0) && (r_nm >= 4'd1) && (r_nm <= MON_DEC)
                 && (r_ny >= YEAR_LO) && (r_ny <= YEAR_HI)
                 && (r_nd <= month_len(r_nm, op_leap));

    assign len_cur   = month_len(r_month, r_leap);
    assign left      = len_cur - r_day;
    assign cnt_zero  = (r_cnt == '0);
    assign fits      = r_cnt <= CNT_W'(left);
    assign ovf_hit   = !cnt_zero && !fits && (r_month == MON_DEC) && (r_year >= YEAR_HI);
    assign year_wrap = !cnt_zero && !fits && (r_month == MON_DEC) && !ovf_hit;

    assign wd_sum = SUM_W'(yy) + SUM_W'(r_op) - SUM_W'(r_q100) + SUM_W'(r_q100[7:2])
                  + SUM_W'(wk_offset(r_month)) + SUM_W'(r_day);

    always_comb begin
        n_cnt    = r_cnt;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_wday   = r_wday;
        n_leap   = r_leap;
        n_status = r_status;
        add5     = '0;
        if (i_cmd.capture) begin
            n_cnt    = (i_in.mode == MODE_NEXT) ? CNT_W'(1) : i_in.day_count;
            n_status = ST_OK;
        end else if (i_cmd.set_chk) begin
            if (set_ok) begin
                n_day   = r_nd;
                n_month = r_nm;
                n_year  = r_ny;
                n_leap  = op_leap;
            end else begin
                n_status = ST_INVALID;
            end
        end else if (i_cmd.leap_upd) begin
            n_leap = op_leap;
        end else if (i_cmd.wday_load) begin
            n_wday = mod7_15(r_sum);
        end else if (i_cmd.next_day) begin
            n_cnt = CNT_W'(1);
        end else if (i_cmd.adv_step) begin
            if (fits) begin
                add5  = r_cnt[DAY_W-1:0];
                n_day = r_day + add5;
                n_cnt = '0;
            end else if (ovf_hit) begin
                // saturate at the last day of the range
                add5     = DAY_LAST_DEC - r_day;
                n_day    = DAY_LAST_DEC;
                n_cnt    = '0;
                n_status = ST_OVERFLOW;
            end else begin
                add5  = left + DAY_W'(1);
                n_day = DAY_W'(1);
                n_cnt = r_cnt - CNT_W'(add5);
                if (r_month == MON_DEC) begin
                    n_month = 4'd1;
                    n_year  = r_year + YEAR_W'(1);
                end else begin
                    n_month = r_month + MON_W'(1);
                end
            end
            n_wday = mod7_6({3'b000, r_wday} + {1'b0, add5});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= RST_DAY;
            r_month     <= RST_MONTH;
            r_year      <= RST_YEAR;
            r_wday      <= RST_WDAY;
            r_leap      <= 1'b0;
            r_status    <= ST_OK;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_wday   <= n_wday;
            r_leap   <= n_leap;
            r_status <= n_status;
            r_cnt    <= n_cnt;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_in.mode;
            r_nd   <= i_in.new_day;
            r_nm   <= i_in.new_month;
            r_ny   <= i_in.new_year;
        end
        if (i_cmd.mul) begin
            r_op   <= src_val;
            r_prod <= PROD_W'(src_val) * PROD_W'(RECIP25);
        end
        if (i_cmd.q_load) begin
            r_q100 <= quot[7:0];
        end
        if (i_cmd.sum_load) begin
            r_sum <= wd_sum;
        end
        if (i_cmd.out_load) begin
            r_out.cur_day   <= r_day;
            r_out.cur_month <= r_month;
            r_out.cur_year  <= r_year;
            r_out.weekday   <= r_wday;
            r_out.is_leap   <= r_leap;
            r_out.status    <= r_status;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.set_ok    = set_ok;
    assign o_sts.cnt_zero  = cnt_zero;
    assign o_sts.weekend   = (r_wday == WD_SUN) || (r_wday == WD_SAT);
    assign o_sts.ovf_hit   = ovf_hit;
    assign o_sts.year_wrap = year_wrap;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/cdc_ctrl.sv @@
module cdc_ctrl import cdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LPM  = 11'b000_0000_0010,
        S_SET  = 11'b000_0000_0100,
        S_WDM  = 11'b000_0000_1000,
        S_WDQ  = 11'b000_0001_0000,
        S_WDS  = 11'b000_0010_0000,
        S_WDR  = 11'b000_0100_0000,
        S_ADV  = 11'b000_1000_0000,
        S_LYM  = 11'b001_0000_0000,
        S_LYU  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_mode)
                        MODE_SET:  n_state = S_LPM;
                        MODE_ADD:  n_state = S_ADV;
                        MODE_NEXT: n_state = S_ADV;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_LPM: begin
                o_cmd.mul = 1'b1;
                o_cmd.src = SRC_NEWY;
                n_state   = S_SET;
            end
            S_SET: begin
                o_cmd.set_chk = 1'b1;
                n_state       = i_sts.set_ok ? S_WDM : S_FIN;
            end
            S_WDM: begin
                o_cmd.mul = 1'b1;
                o_cmd.src = SRC_YYQ4;
                n_state   = S_WDQ;
            end
            S_WDQ: begin
                o_cmd.q_load = 1'b1;
                n_state      = S_WDS;
            end
            S_WDS: begin
                o_cmd.sum_load = 1'b1;
                n_state        = S_WDR;
            end
            S_WDR: begin
                o_cmd.wday_load = 1'b1;
                n_state         = S_FIN;
            end
            S_ADV: begin
                if (i_sts.cnt_zero) begin
                    // next working day keeps stepping over weekends
                    if ((i_sts.mode == MODE_NEXT) && i_sts.weekend) begin
                        o_cmd.next_day = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.adv_step = 1'b1;
                    if (i_sts.ovf_hit) begin
                        n_state = S_FIN;
                    end else if (i_sts.year_wrap) begin
                        n_state = S_LYM;
                    end
                end
            end
            S_LYM: begin
                o_cmd.mul = 1'b1;
                o_cmd.src = SRC_YEAR;
                n_state   = S_LYU;
            end
            S_LYU: begin
                o_cmd.leap_upd = 1'b1;
                n_state        = S_ADV;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/calendar_date_counter.sv @@
// channel   direction  handshake                  payload
// in        into       i_in_valid / o_in_ready    i_in_data  (t_in: command item)
// out       out of     o_out_valid / i_out_ready  o_out_data (t_out: date result item)
//
// one item at a time; a set checks the date, then on success works out the weekday
// before the result; an add walks one step per month crossed, with a leap update per
// year crossed; next working day walks one to three days
// reset (synchronous, active low) returns the date to thursday 1 january 1970
// the result sits in an output register, so a new item is taken while it waits;
// the next result is held back until the previous one has been taken
module calendar_date_counter import cdc_pkg::*; #(
    parameter int MAX_YEAR = 9999,
    parameter int MIN_YEAR = 1970
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // command and status between the sequencer and the datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: picks the path per command, walks months, steps over weekends
    cdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_in_data.mode),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // datapath: date registers, shared divide-by-25 unit for leap year and
    // weekday, incremental weekday tracking and the output register
    cdc_dp #(
        .MAX_YEAR (MAX_YEAR),
        .MIN_YEAR (MIN_YEAR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

@@ tb/sv/calendar_date_counter_chk.sv @@
module calendar_date_counter_chk import cdc_pkg::*; #(
    parameter int MAX_YEAR = 9999,
    parameter int MIN_YEAR = 1970
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // month term of the weekday sum, january first
    localparam int unsigned MONTH_TERM [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    int unsigned cal_day;
    int unsigned cal_month;
    int unsigned cal_year;
    t_out        owed_dates [$];
    int          mismatches = 0;

    function automatic bit year_is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_span(input int unsigned m, input int unsigned y);
        if (m == MON_FEB) begin
            return year_is_leap(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int unsigned weekday_from(input int unsigned d, input int unsigned m,
                                                 input int unsigned y);
        int unsigned yy;
        yy = y;
        if (m < MON_MAR && yy > 0) begin
            yy = yy - 1;
        end
        return (yy + yy / 4 - yy / 100 + yy / 400 + MONTH_TERM[(m - 1) % 12] + d) % 7;
    endfunction

    // walks forward n days; 1 when the end of the calendar was hit
    function automatic bit step_days(input int unsigned n);
        int unsigned room;
        while (n > 0) begin
            room = month_span(cal_month, cal_year) - cal_day;
            if (n <= room) begin
                cal_day = cal_day + n;
                return 1'b0;
            end
            if (cal_month == MON_DEC && cal_year >= MAX_YEAR) begin
                cal_day = DAY_LAST_DEC;
                return 1'b1;
            end
            n = n - (room + 1);
            cal_day = 1;
            if (cal_month == MON_DEC) begin
                cal_month = 1;
                cal_year = cal_year + 1;
            end else begin
                cal_month = cal_month + 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out apply_cmd(input t_in cmd);
        t_out            res;
        logic [ST_W-1:0] st;
        int unsigned     wd;
        bit              hit;
        st = ST_OK;
        case (cmd.mode)
            MODE_SET: begin
                if (cmd.new_day >= 1 && cmd.new_month >= 1 && cmd.new_month <= 12 &&
                    cmd.new_year >= MIN_YEAR && cmd.new_year <= MAX_YEAR &&
                    cmd.new_day <= month_span(cmd.new_month, cmd.new_year)) begin
                    cal_day = cmd.new_day;
                    cal_month = cmd.new_month;
                    cal_year = cmd.new_year;
                end else begin
                    st = ST_INVALID;
                end
            end
            MODE_ADD: begin
                if (step_days(cmd.day_count)) begin
                    st = ST_OVERFLOW;
                end
            end
            MODE_NEXT: begin
                do begin
                    hit = step_days(1);
                    wd = weekday_from(cal_day, cal_month, cal_year);
                end while (!hit && (wd == WD_SUN || wd == WD_SAT));
                if (hit) begin
                    st = ST_OVERFLOW;
                end
            end
            default: begin
            end
        endcase
        res.cur_day = DAY_W'(cal_day);
        res.cur_month = MON_W'(cal_month);
        res.cur_year = YEAR_W'(cal_year);
        res.weekday = WD_W'(weekday_from(cal_day, cal_month, cal_year));
        res.is_leap = year_is_leap(cal_year);
        res.status = st;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            cal_day = RST_DAY;
            cal_month = RST_MONTH;
            cal_year = RST_YEAR;
            owed_dates.delete();
        end else begin
            // result first: it belongs to an item taken at an earlier edge
            if (i_out_valid && i_out_ready) begin
                if (owed_dates.size() == 0) begin
                    $error("result item with no command outstanding");
                    mismatches++;
                end else begin
                    want = owed_dates.pop_front();
                    check_field("cur_day", want.cur_day, i_out_data.cur_day);
                    check_field("cur_month", want.cur_month, i_out_data.cur_month);
                    check_field("cur_year", want.cur_year, i_out_data.cur_year);
                    check_field("weekday", want.weekday, i_out_data.weekday);
                    check_field("is_leap", want.is_leap, i_out_data.is_leap);
                    check_field("status", want.status, i_out_data.status);
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_dates.push_back(apply_cmd(i_in_data));
            end
        end
        o_pending = owed_dates.size();
        o_fail_count = mismatches;
    end

endmodule

@@ tb/sv/calendar_date_counter_tb.sv @@
module calendar_date_counter_tb import cdc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_YEAR = 9999;
    localparam int MIN_YEAR = 1970;

    // the spare command code, which only reports the date
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // random items in each of the four idling phases
    localparam int PHASE_ITEMS = 288;
    // a max add from 1970 is the longest walk; only a few of those are
    // sent, so the whole run stays far below this even with heavy stalling
    localparam int RUN_LIMIT = 3_000_000;
    // settle time once nothing is owed, to catch a stray result item
    localparam int DRAIN_CYCLES = 64;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    int fail_count;
    int pending;
    int in_idle_pct;
    int out_stall_pct;
    int cycles;

    calendar_date_counter #(
        .MAX_YEAR(MAX_YEAR),
        .MIN_YEAR(MIN_YEAR)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    // watches both channels, predicts every date and compares
    calendar_date_counter_chk #(
        .MAX_YEAR(MAX_YEAR),
        .MIN_YEAR(MIN_YEAR)
    ) chk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_data(o_out_data),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: one draw per falling edge, so ready can change only once per cycle
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // watchdog on a hung or silent block
    initial begin
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("calendar_date_counter regression: fail");
        $finish;
    end

    function automatic t_in make_cmd(input logic [MODE_W-1:0] mode, input int unsigned d,
                                     input int unsigned m, input int unsigned y,
                                     input int unsigned cnt);
        t_in cmd;
        cmd.mode = mode;
        cmd.new_day = DAY_W'(d);
        cmd.new_month = MON_W'(m);
        cmd.new_year = YEAR_W'(y);
        cmd.day_count = CNT_W'(cnt);
        return cmd;
    endfunction

    // called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high so the next call (or the
    // end of stimulus) makes the one assignment of that step
    task automatic push_cmd(input t_in cmd);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= cmd;
        // ready is read at the rising edge, before the block updates it
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_in cmd;
        int  pick;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items, no idling on either side
        // spare code straight after reset, every field bit high
        push_cmd(make_cmd(MODE_SPARE, 31, 15, 16383, 65535));
        // zero count leaves the date alone
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 0));
        // thursday to friday, then friday over the weekend to monday
        push_cmd(make_cmd(MODE_NEXT, 0, 0, 0, 0));
        push_cmd(make_cmd(MODE_NEXT, 0, 0, 0, 0));
        // leap day in a year divisible by 400, then on into march
        push_cmd(make_cmd(MODE_SET, 28, 2, 2000, 0));
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 1));
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 1));
        // century years: 2100 has no leap day, 2400 has one
        push_cmd(make_cmd(MODE_SET, 29, 2, 2100, 0));
        push_cmd(make_cmd(MODE_SET, 29, 2, 2400, 0));
        // rejected sets: day zero, month zero, all ones, april 31st,
        // year just below and just above the range
        push_cmd(make_cmd(MODE_SET, 0, 5, 2000, 0));
        push_cmd(make_cmd(MODE_SET, 1, 0, 2000, 0));
        push_cmd(make_cmd(MODE_SET, 31, 15, 16383, 0));
        push_cmd(make_cmd(MODE_SET, 31, 4, 2020, 0));
        push_cmd(make_cmd(MODE_SET, 1, 1, MIN_YEAR - 1, 0));
        push_cmd(make_cmd(MODE_SET, 1, 1, MAX_YEAR + 1, 0));
        // lowest valid date, then the largest count the field holds
        push_cmd(make_cmd(MODE_SET, 1, 1, MIN_YEAR, 0));
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 65535));
        // december into the next year
        push_cmd(make_cmd(MODE_SET, 31, 12, 2023, 0));
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 1));
        // last date of the calendar: any step saturates
        push_cmd(make_cmd(MODE_SET, 31, 12, MAX_YEAR, 0));
        push_cmd(make_cmd(MODE_NEXT, 0, 0, 0, 0));
        push_cmd(make_cmd(MODE_SET, 1, 12, MAX_YEAR, 0));
        push_cmd(make_cmd(MODE_ADD, 0, 0, 0, 65535));
        // one day short of the end: next working day still fits
        push_cmd(make_cmd(MODE_SET, 30, 12, MAX_YEAR, 0));
        push_cmd(make_cmd(MODE_NEXT, 0, 0, 0, 0));

        // random items in four idling phases: none, sender idle, receiver
        // stalling, then both lightly
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct = 76;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct = 76;
                end
                default: begin
                    in_idle_pct = 22;
                    out_stall_pct = 22;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                // unused fields carry noise so every bit gets exercised
                cmd.new_day = DAY_W'($urandom_range(0, 31));
                cmd.new_month = MON_W'($urandom_range(0, 15));
                cmd.new_year = YEAR_W'($urandom_range(0, 16383));
                cmd.day_count = CNT_W'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    cmd.mode = MODE_SET;
                    // mostly plausible dates; the rest stays as noise,
                    // which is nearly always rejected
                    if ($urandom_range(0, 99) < 75) begin
                        cmd.new_month = MON_W'($urandom_range(1, 12));
                        cmd.new_day = DAY_W'(($urandom_range(0, 99) < 80)
                                             ? $urandom_range(1, 28)
                                             : $urandom_range(29, 31));
                        pick = $urandom_range(0, 99);
                        if (pick < 85) begin
                            cmd.new_year = YEAR_W'($urandom_range(MIN_YEAR, 2500));
                        end else if (pick < 95) begin
                            // close to the end, so advances saturate now and then
                            cmd.new_year = YEAR_W'($urandom_range(MAX_YEAR - 9, MAX_YEAR));
                        end else begin
                            cmd.new_year = YEAR_W'($urandom_range(MIN_YEAR, MAX_YEAR));
                        end
                    end
                end else if (pick < 70) begin
                    cmd.mode = MODE_ADD;
                    // long walks are slow in the block, so only a few
                    pick = $urandom_range(0, 99);
                    if (pick < 20) begin
                        cmd.day_count = CNT_W'($urandom_range(0, 7));
                    end else if (pick >= 4) begin
                        cmd.day_count = CNT_W'($urandom_range(0, 400));
                    end
                    if (pick < 4) begin
                        cmd.day_count = CNT_W'($urandom_range(0, 65535));
                    end
                end else if (pick < 95) begin
                    cmd.mode = MODE_NEXT;
                end else begin
                    cmd.mode = MODE_SPARE;
                end
                push_cmd(cmd);
            end
        end
        i_in_valid <= 1'b0;

        // every owed date back, then a short settle for anything extra
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("calendar_date_counter regression: pass");
        end else begin
            $display("calendar_date_counter regression: fail");
        end
        $finish;
    end

endmodule
